@@ rtl/core/eeg_pkg.sv @@
// ----------------------------------------------------------------------------
// eeg_pkg
// Shared types and constants for the extended Euclid gcd unit.
// ----------------------------------------------------------------------------
package eeg_pkg;

    localparam int COEFF_WIDTH = 64;
    localparam int DIV_WIDTH   = 63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // start strobe and busy level from sequencer to datapath units
    typedef struct packed {
        logic start;
        logic busy;
    } t_unit_ctl;

endpackage

@@ rtl/core/extended_euclid_gcd_unit.sv @@
// ----------------------------------------------------------------------------
// extended_euclid_gcd_unit
// Extended Euclid: gcd and signed Bezout coefficients of two operands.
// ----------------------------------------------------------------------------
// One word is worked at a time. Each Euclid round runs a check, then a
// bit-serial divider, then a bit-serial shift-subtract for the two new
// coefficients; a word takes up to about 90 rounds at 63 bits.
// The result is held in output registers until taken; the next word is
// accepted once the result has moved into the output registers.
module extended_euclid_gcd_unit #(
    parameter int OPERAND_WIDTH = 63
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [62:0]                        i_first_operand,
    input  logic [62:0]                        i_second_operand,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [62:0]                        o_divisor,
    output logic signed [63:0]                 o_coeff_first,
    output logic signed [63:0]                 o_coeff_second
);
    localparam int W   = OPERAND_WIDTH;
    localparam int CWD = eeg_pkg::COEFF_WIDTH;

    eeg_pkg::t_state r_state, n_state;
    logic [W-1:0]   r_a, r_b;
    logic [CWD-1:0] r_u, r_x, r_v, r_y;
    logic           r_ovalid;
    eeg_pkg::t_unit_ctl w_div_ctl, w_mul_ctl;
    logic           w_div_done, w_mul_done;
    logic [W-1:0]   w_quo, w_rem;
    logic [CWD-1:0] w_nx, w_ny;
    logic           w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_ovalid && !i_stall;
    assign o_stall   = (r_state != eeg_pkg::ST_IDLE);
    assign o_valid   = r_ovalid;

    // sequencer
    always_comb begin
        n_state        = r_state;
        w_div_ctl      = '0;
        w_mul_ctl      = '0;
        case (r_state)
            eeg_pkg::ST_IDLE:  if (w_in_acc) n_state = eeg_pkg::ST_CHECK;
            eeg_pkg::ST_CHECK: begin
                if (r_b == '0) n_state = eeg_pkg::ST_DONE;
                else begin
                    w_div_ctl.start = 1'b1;
                    n_state = eeg_pkg::ST_DIV;
                end
            end
            eeg_pkg::ST_DIV: begin
                w_div_ctl.busy = 1'b1;
                if (w_div_done) begin
                    w_mul_ctl.start = 1'b1;
                    n_state = eeg_pkg::ST_MUL;
                end
            end
            eeg_pkg::ST_MUL: begin
                w_mul_ctl.busy = 1'b1;
                if (w_mul_done) n_state = eeg_pkg::ST_CHECK;
            end
            eeg_pkg::ST_DONE:  if (!r_ovalid || w_out_acc) n_state = eeg_pkg::ST_IDLE;
            default:           n_state = eeg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= eeg_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_acc) r_ovalid <= 1'b0;
            if (r_state == eeg_pkg::ST_DONE && (!r_ovalid || w_out_acc))
                r_ovalid <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a <= i_first_operand[W-1:0];
            r_b <= i_second_operand[W-1:0];
            r_u <= CWD'(1);
            r_x <= '0;
            r_v <= '0;
            r_y <= CWD'(1);
        end
        if (r_state == eeg_pkg::ST_DIV && w_div_done) begin
            r_a <= r_b;
            r_b <= w_rem;
        end
        if (r_state == eeg_pkg::ST_MUL && w_mul_done) begin
            r_u <= r_x;
            r_x <= w_nx;
            r_v <= r_y;
            r_y <= w_ny;
        end
        if (r_state == eeg_pkg::ST_DONE && (!r_ovalid || w_out_acc)) begin
            o_divisor      <= 63'(r_a);
            o_coeff_first  <= r_u;
            o_coeff_second <= r_v;
        end
    end

    eeg_divider #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_ctl.start),
        .i_num   (r_a),
        .i_den   (r_b),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // quotient is taken straight from the divider as the coefficient step starts
    eeg_mulsub #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_ctl.start),
        .i_quo   (w_quo),
        .i_u     (r_u),
        .i_x     (r_x),
        .i_v     (r_v),
        .i_y     (r_y),
        .o_done  (w_mul_done),
        .o_nx    (w_nx),
        .o_ny    (w_ny)
    );

    // unit done strobes only arrive in their own phase
    a_div_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> w_div_ctl.busy) else $error("divide done out of phase");
    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> w_mul_ctl.busy) else $error("mulsub done out of phase");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_divisor))
        else $error("result dropped under stall");
endmodule

@@ rtl/core/eeg_divider.sv @@
// ----------------------------------------------------------------------------
// eeg_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eeg_divider #(
    parameter int W = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_q, n_q;
    logic [W-1:0]  r_r, n_r;
    logic [W-1:0]  r_d;
    logic          r_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    // one shift-subtract step
    always_comb begin
        w_trial = {r_r, r_q[W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_r     = r_r;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_q    = i_num;
            n_r    = '0;
        end else if (r_busy) begin
            if (w_diff[W]) begin
                n_r = w_trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b0};
            end else begin
                n_r = w_diff[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= r_busy && (r_cnt == CW'(1)) && !i_start;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) r_d <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

    // done only follows a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("divider done without busy");
    // a running division is not dropped before its count reaches one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != CW'(1) |=> r_busy) else $error("divider aborted");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count underflow");
endmodule

@@ rtl/core/eeg_mulsub.sv @@
// ----------------------------------------------------------------------------
// eeg_mulsub
// Bit-serial shift-subtract computing u - q*x and v - q*y modulo 2^64.
// ----------------------------------------------------------------------------
module eeg_mulsub #(
    parameter int W = 63
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [W-1:0]                      i_quo,
    input  logic [eeg_pkg::COEFF_WIDTH-1:0]   i_u,
    input  logic [eeg_pkg::COEFF_WIDTH-1:0]   i_x,
    input  logic [eeg_pkg::COEFF_WIDTH-1:0]   i_v,
    input  logic [eeg_pkg::COEFF_WIDTH-1:0]   i_y,
    output logic                              o_done,
    output logic [eeg_pkg::COEFF_WIDTH-1:0]   o_nx,
    output logic [eeg_pkg::COEFF_WIDTH-1:0]   o_ny
);
    localparam int CWD = eeg_pkg::COEFF_WIDTH;
    localparam int CW  = $clog2(W + 1);

    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    logic [W-1:0]   r_q;
    logic [CWD-1:0] r_x, r_y, r_ax, r_ay;
    logic           r_done;

    // q bit k scales shifted x; accumulate the subtraction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q  <= i_quo;
            r_x  <= i_x;
            r_y  <= i_y;
            r_ax <= i_u;
            r_ay <= i_v;
        end else if (r_busy) begin
            if (r_q[0]) begin
                r_ax <= r_ax - r_x;
                r_ay <= r_ay - r_y;
            end
            r_q <= r_q >> 1;
            r_x <= r_x << 1;
            r_y <= r_y << 1;
        end
    end

    assign o_done = r_done;
    assign o_nx   = r_ax;
    assign o_ny   = r_ay;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("mulsub done without busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("mulsub count underflow");
    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("mulsub double done");
endmodule
